[hw/rtl/wbcd_pkg.sv]
// Shared types, constants and helper functions for the weighted BCD codec.
// No dependencies; every other file of the block imports this package.
package wbcd_pkg;

    localparam int NUM_CODES    = 10;
    localparam int NUM_NIBBLES  = 16;
    localparam int WORD_NIBBLES = 8;
    localparam int DD_ITERS     = 7;   // double-dabble steps per conversion stage

    // Configuration register indexes
    localparam logic [2:0] CFG_WEIGHT_MSB  = 3'd0;
    localparam logic [2:0] CFG_WEIGHT_BIT2 = 3'd1;
    localparam logic [2:0] CFG_WEIGHT_BIT1 = 3'd2;
    localparam logic [2:0] CFG_WEIGHT_LSB  = 3'd3;
    localparam logic [2:0] CFG_DIGITS      = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd1;
    localparam logic [1:0] ST_NO_CODE    = 2'd2;
    localparam logic [1:0] ST_BAD_NIBBLE = 2'd3;

    localparam logic [0:0] CMD_ENCODE = 1'b0;

    // Reset weights (8421)
    localparam logic [4:0] RST_W3 = 5'd8;
    localparam logic [4:0] RST_W2 = 5'd4;
    localparam logic [4:0] RST_W1 = 5'd2;
    localparam logic [4:0] RST_W0 = 5'd1;

    typedef struct packed {
        logic       vld;
        logic [3:0] nib;
    } t_fwd;

    typedef struct packed {
        logic       vld;
        logic [3:0] digit;
    } t_rev;

    typedef t_fwd [NUM_CODES-1:0]   t_fwd_tab;
    typedef t_rev [NUM_NIBBLES-1:0] t_rev_tab;

    // One item in flight through the conversion stages
    typedef struct packed {
        logic        cmd;
        logic [3:0]  n;      // active digit count, 1..8
        logic        over;   // encode: value does not fit
        logic        bad;    // decode: a nibble has no digit
        logic [31:0] bcd;    // encode: decimal digits being built
        logic [27:0] bin;    // encode: binary bits still to shift in
        logic [31:0] dig;    // decode: digits still to accumulate, top first
        logic [26:0] acc;    // decode: running binary value
    } t_item;

    function automatic logic signed [6:0] nib_sum(input logic [4:0] w3, input logic [4:0] w2,
                                                  input logic [4:0] w1, input logic [4:0] w0,
                                                  input logic [3:0] nib);
        logic signed [6:0] s;
        s = '0;
        if (nib[3]) s = s + $signed({{2{w3[4]}}, w3});
        if (nib[2]) s = s + $signed({{2{w2[4]}}, w2});
        if (nib[1]) s = s + $signed({{2{w1[4]}}, w1});
        if (nib[0]) s = s + $signed({{2{w0[4]}}, w0});
        return s;
    endfunction

    // Digit -> lowest nibble whose weighted sum equals it
    function automatic t_fwd_tab build_fwd(input logic [4:0] w3, input logic [4:0] w2,
                                           input logic [4:0] w1, input logic [4:0] w0);
        t_fwd_tab          tab;
        logic signed [6:0] s;
        tab = '0;
        for (int d = 0; d < NUM_CODES; d++) begin
            for (int n = NUM_NIBBLES - 1; n >= 0; n--) begin
                s = nib_sum(w3, w2, w1, w0, 4'(n));
                if (!s[6] && s[5:0] == 6'(d)) begin
                    tab[d].vld = 1'b1;
                    tab[d].nib = 4'(n);
                end
            end
        end
        return tab;
    endfunction

    // Nibble -> digit; only the lowest nibble of each sum is a code
    function automatic t_rev_tab build_rev(input logic [4:0] w3, input logic [4:0] w2,
                                           input logic [4:0] w1, input logic [4:0] w0);
        t_rev_tab                           tab;
        logic signed [NUM_NIBBLES-1:0][6:0] s;
        for (int n = 0; n < NUM_NIBBLES; n++) begin
            s[n] = nib_sum(w3, w2, w1, w0, 4'(n));
        end
        for (int n = 0; n < NUM_NIBBLES; n++) begin
            tab[n].vld   = !s[n][6] && (s[n] < 7'sd10);
            tab[n].digit = s[n][3:0];
            for (int m = 0; m < NUM_NIBBLES; m++) begin
                if (m < n && s[m] == s[n]) tab[n].vld = 1'b0;
            end
        end
        return tab;
    endfunction

    // One shift-add-3 step on eight BCD digits
    function automatic logic [31:0] dd_step(input logic [31:0] bcd, input logic bit_in);
        logic [31:0] adj;
        for (int k = 0; k < WORD_NIBBLES; k++) begin
            adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
        end
        return {adj[30:0], bit_in};
    endfunction

    function automatic logic [26:0] pow10(input logic [3:0] n);
        logic [26:0] p;
        case (n)
            4'd1:    p = 27'd10;
            4'd2:    p = 27'd100;
            4'd3:    p = 27'd1000;
            4'd4:    p = 27'd10000;
            4'd5:    p = 27'd100000;
            4'd6:    p = 27'd1000000;
            4'd7:    p = 27'd10000000;
            default: p = 27'd100000000;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/weighted_bcd_codec_core.sv]
// Top level of the weighted BCD codec: stream ports, front stages, four
// conversion stages and the output stage. Depends on wbcd_pkg, wbcd_cfg,
// wbcd_conv_stage.
//
// Converts between binary numbers and a four-bit weighted decimal code
// whose bit weights are set through the configuration port. tuser selects
// the operation: 0 encodes binary_value into code nibbles, 1 decodes
// code_word back to binary. Every transfer in yields exactly one result.
// The block takes one item per clock while the output is not stalled and
// holds up to seven items in flight. Seven register stages set that
// depth, most of it from the binary-to-decimal conversion: 28 shift-add-3
// steps spread over four stages of seven steps (decode runs its eight
// multiply-by-ten steps alongside, two per stage). Each stage has its
// own valid bit and holds on a stall, so bubbles are squeezed out and
// an input transfer is taken while a finished result waits on the
// output. The code tables are registered and rebuilt the cycle after a
// weight write; write configuration only while no item is in flight.
// Status: 0 ok, 1 number too large, 2 digit lacks code, 3 nibble not
// allowed. encoded_word is 0 on decode and on encode errors,
// decoded_value is 0 on encode and partial on a bad nibble.
module weighted_bcd_codec_core
    import wbcd_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [26:0] binary_value, [58:27] code_word, rest 0
    input  logic        s_axis_tuser,   // [0] command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] encoded_word, [58:32] decoded_value,
                                        // [60:59] status, rest 0
);

    // digit count is capped by the parameter and by the eight-nibble word
    localparam int DIGIT_CAP_I = (MAX_DIGITS > WORD_NIBBLES) ? WORD_NIBBLES :
                                 (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
    localparam logic [3:0] DIGIT_CAP = 4'(DIGIT_CAP_I);
    localparam int NUM_CONV = 4;

    typedef struct packed {
        logic        cmd;
        logic [26:0] value;
        logic [31:0] word;
        logic [3:0]  n;
    } t_raw;

    logic [3:0] cfg_digits;
    t_fwd_tab   fwd_tab;
    t_rev_tab   rev_tab;

    wbcd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_digits    (cfg_digits),
        .o_fwd       (fwd_tab),
        .o_rev       (rev_tab)
    );

    assign o_cfg_ready = 1'b1;

    // ---------------- stage 1: capture the transfer and the digit count
    logic r_s1_valid;
    t_raw r_s1;
    t_raw n_s1;
    logic s1_ready;
    logic s2_ready;

    always_comb begin
        n_s1.cmd   = s_axis_tuser;
        n_s1.value = s_axis_tdata[26:0];
        n_s1.word  = s_axis_tdata[58:27];
        if (cfg_digits == 4'd0) begin
            n_s1.n = 4'd1;
        end else if (cfg_digits > DIGIT_CAP) begin
            n_s1.n = DIGIT_CAP;
        end else begin
            n_s1.n = cfg_digits;
        end
    end

    assign s1_ready      = !r_s1_valid || s2_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stage 2: range check, nibble lookup, digit masking
    logic  r_s2_valid;
    t_item r_s2;
    t_item n_s2;
    logic  conv_ready [NUM_CONV+1];
    logic  conv_valid [NUM_CONV+1];
    t_item conv_item  [NUM_CONV+1];

    always_comb begin
        logic ok;
        logic act;
        logic inv;
        t_rev ent;
        n_s2.cmd  = r_s1.cmd;
        n_s2.n    = r_s1.n;
        n_s2.over = (r_s1.value >= pow10(r_s1.n));
        n_s2.bcd  = '0;
        n_s2.bin  = {1'b0, r_s1.value};
        n_s2.acc  = '0;
        n_s2.dig  = '0;
        n_s2.bad  = 1'b0;
        ok        = 1'b1;
        // walk from the most significant nibble; drop digits below a bad one
        for (int k = WORD_NIBBLES - 1; k >= 0; k--) begin
            ent = rev_tab[r_s1.word[4*k +: 4]];
            act = (4'(k) < r_s1.n);
            inv = act && !ent.vld;
            ok  = ok && !inv;
            if (act && ok) n_s2.dig[4*k +: 4] = ent.digit;
            n_s2.bad = n_s2.bad || inv;
        end
    end

    assign s2_ready = !r_s2_valid || conv_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- stages 3..6: conversion
    assign conv_valid[0] = r_s2_valid;
    assign conv_item[0]  = r_s2;

    for (genvar g = 0; g < NUM_CONV; g++) begin : g_conv
        wbcd_conv_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (conv_valid[g]),
            .o_ready (conv_ready[g]),
            .i_item  (conv_item[g]),
            .o_valid (conv_valid[g+1]),
            .i_ready (conv_ready[g+1]),
            .o_item  (conv_item[g+1])
        );
    end

    // ---------------- stage 7: code mapping, status, output register
    logic        r_out_valid;
    logic [31:0] r_enc;
    logic [26:0] r_dec;
    logic [1:0]  r_status;
    logic [31:0] n_enc;
    logic [26:0] n_dec;
    logic [1:0]  n_status;
    t_item       fin;

    assign fin = conv_item[NUM_CONV];

    always_comb begin
        logic [3:0]  d;
        logic        lack;
        logic [31:0] word;
        t_fwd        ent;
        lack = 1'b0;
        word = '0;
        for (int k = 0; k < WORD_NIBBLES; k++) begin
            d   = fin.bcd[4*k +: 4];
            ent = (d < 4'(NUM_CODES)) ? fwd_tab[d] : '0;
            if (4'(k) < fin.n) begin
                lack = lack || !ent.vld;
                word[4*k +: 4] = ent.nib;
            end
        end
        if (fin.cmd == CMD_ENCODE) begin
            n_dec = '0;
            if (fin.over) begin
                n_status = ST_TOO_LARGE;
                n_enc    = '0;
            end else if (lack) begin
                n_status = ST_NO_CODE;
                n_enc    = '0;
            end else begin
                n_status = ST_OK;
                n_enc    = word;
            end
        end else begin
            n_enc    = '0;
            n_dec    = fin.acc;
            n_status = fin.bad ? ST_BAD_NIBBLE : ST_OK;
        end
    end

    assign conv_ready[NUM_CONV] = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (conv_ready[NUM_CONV]) begin
            r_out_valid <= conv_valid[NUM_CONV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv_ready[NUM_CONV] && conv_valid[NUM_CONV]) begin
            r_enc    <= n_enc;
            r_dec    <= n_dec;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_status, r_dec, r_enc};

endmodule

[hw/rtl/wbcd_cfg.sv]
// Configuration registers and the registered digit/nibble code tables.
// Depends on wbcd_pkg.
module wbcd_cfg
    import wbcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_index,
    input  logic [4:0] i_cfg_data,
    output logic [3:0] o_digits,
    output t_fwd_tab   o_fwd,
    output t_rev_tab   o_rev
);

    logic [4:0] r_w3, r_w2, r_w1, r_w0;
    logic [3:0] r_digits;
    t_fwd_tab   r_fwd;
    t_rev_tab   r_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w3     <= RST_W3;
            r_w2     <= RST_W2;
            r_w1     <= RST_W1;
            r_w0     <= RST_W0;
            r_digits <= 4'd8;
            r_fwd    <= build_fwd(RST_W3, RST_W2, RST_W1, RST_W0);
            r_rev    <= build_rev(RST_W3, RST_W2, RST_W1, RST_W0);
        end else begin
            // rebuild tables from the current weights, so they follow a write in the next cycle
            r_fwd <= build_fwd(r_w3, r_w2, r_w1, r_w0);
            r_rev <= build_rev(r_w3, r_w2, r_w1, r_w0);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WEIGHT_MSB:  r_w3     <= i_cfg_data;
                    CFG_WEIGHT_BIT2: r_w2     <= i_cfg_data;
                    CFG_WEIGHT_BIT1: r_w1     <= i_cfg_data;
                    CFG_WEIGHT_LSB:  r_w0     <= i_cfg_data;
                    CFG_DIGITS:      r_digits <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_digits = r_digits;
    assign o_fwd    = r_fwd;
    assign o_rev    = r_rev;

endmodule

[hw/rtl/wbcd_conv_stage.sv]
// One conversion pipeline stage: seven double-dabble steps for encode and
// two multiply-by-ten accumulate steps for decode. Depends on wbcd_pkg.
module wbcd_conv_stage
    import wbcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        logic [29:0] acc10;
        n_item = i_item;
        for (int i = 0; i < DD_ITERS; i++) begin
            n_item.bcd = dd_step(n_item.bcd, n_item.bin[27]);
            n_item.bin = {n_item.bin[26:0], 1'b0};
        end
        for (int j = 0; j < 2; j++) begin
            acc10      = {n_item.acc, 3'b000} + {2'b00, n_item.acc, 1'b0};
            n_item.acc = acc10[26:0] + {23'd0, n_item.dig[31:28]};
            n_item.dig = {n_item.dig[27:0], 4'd0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hw/rtl/wbcd_chk.sv]
// Port-level checker for weighted_bcd_codec_core, bound to the top level.
// Depends on wbcd_pkg.
module wbcd_chk
    import wbcd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    logic [31:0] enc;
    logic [26:0] dec;
    logic [1:0]  st;

    assign enc = m_axis_tdata[31:0];
    assign dec = m_axis_tdata[58:32];
    assign st  = m_axis_tdata[60:59];

    // reset flushes every stage
    a_reset_flush: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a result carries either an encoded word or a decoded value, never both
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (enc == 32'd0 || dec == 27'd0))
        else $error("encoded and decoded fields both nonzero");

    // encode errors zero both data fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (st == ST_TOO_LARGE || st == ST_NO_CODE)
        |-> (enc == 32'd0 && dec == 27'd0))
        else $error("encode error with nonzero data");

    // decoded value never exceeds eight decimal digits
    a_dec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (dec <= 27'd99999999))
        else $error("decoded value out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind weighted_bcd_codec_core wbcd_chk u_wbcd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tb.sv]
// Self-checking bench for weighted_bcd_codec_core: encode and decode items run
// through the stream ports while the weight and digit-count settings change.
// Depends on wbcd_pkg for register indexes and status codes, and on the core it tests.
module tb
    import wbcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIGIT_CAP    = 8;
    localparam logic [2:0]  CFG_NO_REG   = 3'd5;   // index with no register behind it
    localparam logic [26:0] BIN_ALL_ONES = 27'h7FFFFFF;

    typedef struct packed {
        logic        cmd;
        logic [26:0] bin;
        logic [31:0] word;
    } t_conv_item;

    typedef struct packed {
        logic [31:0] encoded;
        logic [26:0] decoded;
        logic [1:0]  status;
    } t_conv_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_digit_code;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [4:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;

    // Local copy of the block's settings and the derived digit codes
    logic [4:0]  weight_of_bit [4];
    logic [3:0]  digit_setting;
    t_digit_code code_of_digit [10];

    t_conv_item   items_to_send [$];
    t_conv_result results_due [$];
    int           mismatches = 0;
    bit           idle_on    = 1'b1;
    int           src_gap    = 0;
    int           snk_gap    = 0;
    t_conv_item   next_item;
    t_conv_item   taken_item;
    t_conv_result want;
    t_conv_result got;

    weighted_bcd_codec_core #(
        .MAX_DIGITS(DIGIT_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Rebuild the digit codes: each digit takes the lowest nibble whose weighted
    // sum equals it; negative sums and sums of ten or more code nothing.
    function automatic void rebuild_codes();
        int s;
        for (int d = 0; d < 10; d++) code_of_digit[d] = '0;
        for (int n = 0; n < 16; n++) begin
            s = 0;
            for (int b = 0; b < 4; b++) begin
                if (n[b]) s += int'($signed(weight_of_bit[b]));
            end
            if (s >= 0 && s < 10 && !code_of_digit[s].ok) begin
                code_of_digit[s].ok  = 1'b1;
                code_of_digit[s].nib = n[3:0];
            end
        end
    endfunction

    // Zero acts as one digit; anything above the cap is clamped to it
    function automatic int unsigned digit_span();
        int unsigned n;
        n = {28'd0, digit_setting};
        if (n < 1) n = 1;
        if (n > DIGIT_CAP) n = DIGIT_CAP;
        return n;
    endfunction

    function automatic int unsigned ten_to(input int unsigned n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) p *= 10;
        return p;
    endfunction

    function automatic t_conv_result convert_item(input t_conv_item it);
        t_conv_result r;
        int unsigned  n;
        int unsigned  v;
        int unsigned  pos;
        int unsigned  digit;
        logic [3:0]   nib;
        bit           hit;
        r = '0;
        n = digit_span();
        if (it.cmd == CMD_ENCODE) begin
            v = {5'd0, it.bin};
            if (v >= ten_to(n)) begin
                r.status = ST_TOO_LARGE;
            end else begin
                for (int i = 0; i < n; i++) begin
                    digit = v % 10;
                    v = v / 10;
                    if (!code_of_digit[digit].ok) begin
                        r.status  = ST_NO_CODE;
                        r.encoded = '0;
                        break;
                    end
                    r.encoded[4*i +: 4] = code_of_digit[digit].nib;
                end
            end
        end else begin
            // Walk from the top digit down; stop at the first nibble without a digit
            for (int i = 0; i < n; i++) begin
                pos = n - 1 - i;
                nib = it.word[4*pos +: 4];
                hit = 1'b0;
                digit = 0;
                for (int d = 0; d < 10; d++) begin
                    if (!hit && code_of_digit[d].ok && code_of_digit[d].nib == nib) begin
                        hit = 1'b1;
                        digit = d;
                    end
                end
                if (!hit) begin
                    r.status = ST_BAD_NIBBLE;
                    break;
                end
                r.decoded = r.decoded + 27'(digit * ten_to(pos));
            end
        end
        return r;
    endfunction

    // Driver: present the next pending item once the bus is free, predict on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                taken_item.cmd  = s_axis_tuser;
                taken_item.bin  = s_axis_tdata[26:0];
                taken_item.word = s_axis_tdata[58:27];
                results_due.push_back(convert_item(taken_item));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    next_item = items_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, next_item.word, next_item.bin};
                    s_axis_tuser  <= next_item.cmd;
                    if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.encoded = m_axis_tdata[31:0];
                got.decoded = m_axis_tdata[58:32];
                got.status  = m_axis_tdata[60:59];
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing outstanding: %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (got.encoded !== want.encoded) begin
                        $error("encoded_word: expected %h, got %h", want.encoded, got.encoded);
                        mismatches++;
                    end
                    if (got.decoded !== want.decoded) begin
                        $error("decoded_value: expected %0d, got %0d",
                               want.decoded, got.decoded);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WEIGHT_MSB:  begin weight_of_bit[3] = val; rebuild_codes(); end
            CFG_WEIGHT_BIT2: begin weight_of_bit[2] = val; rebuild_codes(); end
            CFG_WEIGHT_BIT1: begin weight_of_bit[1] = val; rebuild_codes(); end
            CFG_WEIGHT_LSB:  begin weight_of_bit[0] = val; rebuild_codes(); end
            CFG_DIGITS:      digit_setting = val[3:0];
            default: ;
        endcase
    endtask

    // Hold until every item is sent and every result is back, then let the pipe empty
    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_item(input logic cmd, input logic [26:0] bin, input logic [31:0] word);
        t_conv_item it;
        it.cmd  = cmd;
        it.bin  = bin;
        it.word = word;
        items_to_send.push_back(it);
    endtask

    // Mostly well-formed numbers and code words built from digits that have a
    // code under the current weights; the rest is boundary values and noise.
    task automatic random_batch(input int count);
        int          coded [$];
        int unsigned n;
        int unsigned lim;
        int unsigned v;
        int unsigned pick;
        logic [31:0] w;
        coded = {};
        for (int d = 0; d < 10; d++) begin
            if (code_of_digit[d].ok) coded.push_back(d);
        end
        n = digit_span();
        lim = ten_to(n);
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 1) == 0) begin
                if (pick < 2) begin
                    v = $urandom_range(0, BIN_ALL_ONES);
                end else if (pick < 3) begin
                    v = lim - 1 + $urandom_range(0, 1);
                end else if (pick < 6) begin
                    v = $urandom_range(0, lim - 1);
                end else begin
                    v = 0;
                    for (int i = 0; i < n; i++) begin
                        v = v * 10 + coded[$urandom_range(0, coded.size() - 1)];
                    end
                end
                add_item(CMD_ENCODE, 27'(v), $urandom);
            end else begin
                w = $urandom;
                if (pick >= 3) begin
                    for (int i = 0; i < n; i++) begin
                        w[4*i +: 4] = code_of_digit[coded[$urandom_range(0, coded.size() - 1)]].nib;
                    end
                    // break one nibble now and then
                    if (pick == 9) w[4*$urandom_range(0, n - 1) +: 4] = 4'($urandom);
                end
                add_item(~CMD_ENCODE, 27'($urandom), w);
            end
        end
    endtask

    task automatic run_phase(input logic [4:0] w3, input logic [4:0] w2, input logic [4:0] w1,
                             input logic [4:0] w0, input logic [4:0] digits, input int count);
        wait_drained();
        write_reg(CFG_WEIGHT_MSB, w3);
        write_reg(CFG_WEIGHT_BIT2, w2);
        write_reg(CFG_WEIGHT_BIT1, w1);
        write_reg(CFG_WEIGHT_LSB, w0);
        write_reg(CFG_DIGITS, digits);
        // tables rebuild the cycle after a weight write
        repeat (3) @(posedge i_clk);
        random_batch(count);
    endtask

    initial begin
        weight_of_bit[3] = RST_W3;
        weight_of_bit[2] = RST_W2;
        weight_of_bit[1] = RST_W1;
        weight_of_bit[0] = RST_W0;
        digit_setting    = 4'd8;
        rebuild_codes();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings (8421, eight digits): extremes and a few known words
        add_item(CMD_ENCODE, 27'd0, 32'h0);
        add_item(CMD_ENCODE, 27'd99999999, 32'h0);
        add_item(CMD_ENCODE, 27'd100000000, 32'h0);
        add_item(CMD_ENCODE, BIN_ALL_ONES, 32'hFFFFFFFF);
        add_item(CMD_ENCODE, 27'd12345678, 32'h0);
        add_item(CMD_ENCODE, 27'd90817263, 32'h0);
        add_item(~CMD_ENCODE, 27'd0, 32'h0);
        add_item(~CMD_ENCODE, BIN_ALL_ONES, 32'h99999999);
        add_item(~CMD_ENCODE, 27'd0, 32'h12345678);
        add_item(~CMD_ENCODE, 27'd0, 32'hFFFFFFFF);
        add_item(~CMD_ENCODE, 27'd0, 32'h123A5678);
        add_item(~CMD_ENCODE, 27'd0, 32'h0000000F);
        add_item(~CMD_ENCODE, 27'd0, 32'hA0000000);
        random_batch(160);

        // Redundant code with four-digit words, then a negative-weight code
        run_phase(5'd2, 5'd4, 5'd2, 5'd1, 5'd4, 180);
        run_phase(5'd8, 5'd4, -5'sd2, -5'sd1, 5'd8, 180);
        // Weight extremes; zero digits acts as one, fifteen as the cap
        run_phase(-5'sd8, -5'sd8, -5'sd8, -5'sd8, 5'd0, 120);
        run_phase(5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 120);
        run_phase(5'd5, 5'd2, 5'd1, 5'd1, 5'd1, 150);
        // A write to an index with no register must change nothing
        wait_drained();
        write_reg(CFG_NO_REG, 5'h1F);
        random_batch(60);
        run_phase(5'h10, 5'd3, 5'd3, 5'd3, 5'd6, 120);
        repeat (4) begin
            run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 15)), 130);
        end
        // Back to plain 8421 with full speed on both sides
        wait_drained();
        idle_on = 1'b0;
        run_phase(RST_W3, RST_W2, RST_W1, RST_W0, 5'd8, 200);

        wait_drained();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
